### hdl/tscr_pkg.sv
package tscr_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int SAMPLE_W        = SAMPLE_BITS;
	localparam int FAST_W          = 64;
	localparam int DELAY_W         = 31;
	localparam int TICKS_W         = 63;
	localparam int OVS_W           = 16;
	localparam int HALF_W          = FAST_W / 2;
	localparam int PROD_W          = FAST_W + DELAY_W;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 32;

	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(178977);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_CORRECTION = CFG_IDX_W'(1);

	typedef struct packed {
		logic                start_req;
		logic [SAMPLE_W-1:0] timer_sample;
		logic [FAST_W-1:0]   fast_count;
	} tscr_in_t;

	typedef struct packed {
		logic [TICKS_W-1:0] ticks_per_interval;
		logic [OVS_W-1:0]   overshoot_ticks;
	} tscr_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DONE
	} tscr_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL_LO,
		MD_MUL_HI,
		MD_DIV
	} tscr_md_state_t;

	// clamp a 64-bit count into the 63-bit result field
	function automatic logic [TICKS_W-1:0] sat63(input logic [FAST_W-1:0] v);
		logic [TICKS_W-1:0] r;
		r = v[FAST_W-1] ? {TICKS_W{1'b1}} : v[TICKS_W-1:0];
		return r;
	endfunction

endpackage

### hdl/tscr_muldiv.sv
module tscr_muldiv
	import tscr_pkg::*;
(
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [FAST_W-1:0]                  elapsed,
	input  logic [DELAY_W-1:0]                 delay,
	input  logic [((SAMPLE_BITS > DELAY_W) ? SAMPLE_BITS : DELAY_W):0] den,
	output logic                               done,
	output logic [FAST_W-1:0]                  quo
);

	localparam int DEN_W  = ((SAMPLE_BITS > DELAY_W) ? SAMPLE_BITS : DELAY_W) + 1;
	localparam int MUL_W  = HALF_W + DELAY_W;
	localparam int STEP_W = $clog2(PROD_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);

	tscr_md_state_t state_q, state_d;

	logic [FAST_W-1:0]  e_q;
	logic [DELAY_W-1:0] d_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [PROD_W-1:0]  prod_q;
	logic [STEP_W-1:0]  step_q;

	logic [HALF_W-1:0]  mul_a;
	logic [MUL_W-1:0]   mul_p;
	logic [DEN_W:0]     rem_sh;
	logic [DEN_W:0]     rem_sub;
	logic               q_bit;

	// one 32x31 multiplier serves both halves of the fast count
	assign mul_a = (state_q == MD_MUL_LO) ? e_q[HALF_W-1:0] : e_q[FAST_W-1:HALF_W];
	assign mul_p = MUL_W'(mul_a) * MUL_W'(d_q);

	// restoring division, one quotient bit a cycle
	assign rem_sh  = {rem_q, prod_q[PROD_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign q_bit   = (rem_sh >= {1'b0, den_q});

	assign done = (state_q == MD_DIV) && (step_q == LAST_STEP);
	assign quo  = prod_q[FAST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			MD_IDLE:   if (start) state_d = MD_MUL_LO;
			MD_MUL_LO: state_d = MD_MUL_HI;
			MD_MUL_HI: state_d = MD_DIV;
			MD_DIV:    if (step_q == LAST_STEP) state_d = MD_IDLE;
			default:   state_d = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (start) begin
					e_q    <= elapsed;
					d_q    <= delay;
					den_q  <= den;
				end
			end
			MD_MUL_LO: begin
				prod_q <= PROD_W'(mul_p);
			end
			MD_MUL_HI: begin
				prod_q <= prod_q + {mul_p, {HALF_W{1'b0}}};
				rem_q  <= '0;
				step_q <= '0;
			end
			MD_DIV: begin
				rem_q  <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
				prod_q <= {prod_q[PROD_W-2:0], q_bit};
				step_q <= step_q + STEP_W'(1);
			end
			default: ;
		endcase
	end

endmodule

### hdl/tsc_rate_against_reference_timer_unit.sv
// A sample that closes a measurement without correction, or a start with zero delay, shows
// its result in the cycle after acceptance; with correction on, the result follows the low
// and high multiply steps and 95 restoring-division steps in the shared unit, plus
// handover. Throughput: one sample a cycle while measuring and ready; ready stays low for
// the whole correction, set by the one-bit-a-cycle divider. Reset (arst_n low) clears the
// sequencer, the measurement flag and the result flag, and restores the register defaults.
module tsc_rate_against_reference_timer_unit
	import tscr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tscr_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tscr_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// remaining count must hold the full delay and an overshoot of one whole sample span
	localparam int BASE_W = (SAMPLE_BITS > DELAY_W) ? SAMPLE_BITS : DELAY_W;
	localparam int REM_W  = BASE_W + 2;
	localparam int DEN_W  = BASE_W + 1;

	// configuration
	logic [DELAY_W-1:0] delay_q;
	logic               corr_q;

	// measurement state
	logic                   measuring_q;
	logic [SAMPLE_BITS-1:0] prev_q;
	logic [REM_W-1:0]       rem_q;
	logic [FAST_W-1:0]      start_q;
	logic [OVS_W-1:0]       ovs_q;

	tscr_state_t state_q, state_d;

	// result register
	logic      out_valid_q;
	tscr_out_t out_q;

	// per-sample datapath
	logic [CFG_DATA_W-1:0]  smp_ext;
	logic [SAMPLE_BITS-1:0] smp;
	logic [SAMPLE_BITS-1:0] diff;
	logic [REM_W-1:0]       new_rem;
	logic [REM_W-1:0]       neg_rem;
	logic [SAMPLE_BITS-1:0] ovs;
	logic [CFG_DATA_W-1:0]  ovs_ext;
	logic [DEN_W-1:0]       den;
	logic [FAST_W-1:0]      elapsed;

	logic in_acc;
	logic is_start;
	logic start_zero;
	logic fin;
	logic direct;
	logic launch;
	logic out_free;
	logic load_direct;
	logic load_calc;

	logic              md_done;
	logic [FAST_W-1:0] md_quo;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			corr_q  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DELAY_TICKS:      delay_q <= cfg_data[DELAY_W-1:0];
				CFG_ERROR_CORRECTION: corr_q  <= cfg_data[0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	// wrap-aware step of the reference timer
	assign smp_ext = CFG_DATA_W'(in_data.timer_sample);
	assign smp     = smp_ext[SAMPLE_BITS-1:0];
	assign diff    = smp - prev_q;
	assign new_rem = rem_q - REM_W'(diff);
	assign neg_rem = -new_rem;
	assign ovs     = neg_rem[SAMPLE_BITS-1:0];
	assign ovs_ext = CFG_DATA_W'(ovs);
	assign den     = DEN_W'(delay_q) + DEN_W'(ovs);
	assign elapsed = in_data.fast_count - start_q;

	assign is_start   = in_data.start_req;
	assign start_zero = is_start && (delay_q == '0);
	// remaining count reached zero or went negative
	assign fin        = !is_start && measuring_q && (new_rem[REM_W-1] || (new_rem == '0));
	// results that leave in the cycle after acceptance
	assign direct     = start_zero || (fin && (!corr_q || (den == '0)));
	assign launch     = fin && corr_q && (den != '0);

	assign out_free = !out_valid_q || out_ready;
	// only an item that writes the result register straight away needs it free
	assign in_ready = (state_q == ST_IDLE) && (out_free || !direct);
	assign in_acc   = in_valid && in_ready;

	assign load_direct = in_acc && direct;
	assign load_calc   = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc && launch) state_d = ST_CALC;
			ST_CALC: if (md_done) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measuring_q <= 1'b0;
		end else if (in_acc) begin
			if (is_start) begin
				measuring_q <= !start_zero;
			end else if (fin) begin
				measuring_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (is_start) begin
				prev_q  <= smp;
				start_q <= in_data.fast_count;
				rem_q   <= REM_W'(delay_q);
			end else if (measuring_q) begin
				prev_q <= smp;
				rem_q  <= new_rem;
			end
			if (launch) begin
				ovs_q <= ovs_ext[OVS_W-1:0];
			end
		end
	end

	// result register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_direct || load_calc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			if (start_zero || corr_q) begin
				// zero delay, or a zero divisor under correction
				out_q.ticks_per_interval <= '0;
			end else begin
				out_q.ticks_per_interval <= sat63(elapsed);
			end
			out_q.overshoot_ticks <= start_zero ? '0 : ovs_ext[OVS_W-1:0];
		end else if (load_calc) begin
			out_q.ticks_per_interval <= sat63(md_quo);
			out_q.overshoot_ticks    <= ovs_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// elapsed * delay / (delay + overshoot) on one shared multiplier and subtractor
	tscr_muldiv u_muldiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_acc && launch),
		.elapsed (elapsed),
		.delay   (delay_q),
		.den     (den),
		.done    (md_done),
		.quo     (md_quo)
	);

endmodule

### hdl/tscr_checker.sv
module tscr_checker
	import tscr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input tscr_in_t              in_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input tscr_out_t             out_data,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	logic [DELAY_W-1:0] delay_q;

	// shadow of the delay register as seen on the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
		end else if (cfg_valid && cfg_ready && (cfg_index == CFG_DELAY_TICKS)) begin
			delay_q <= cfg_data[DELAY_W-1:0];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	a_zero_delay: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.start_req && (delay_q == '0)
		|=> out_valid && (out_data.ticks_per_interval == '0)
			&& (out_data.overshoot_ticks == '0))
		else $error("zero-delay start did not give an empty result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_valid && in_ready && in_data.start_req
		|-> (delay_q != '0))
		else $error("immediate result accepted over a waiting one");

endmodule

bind tsc_rate_against_reference_timer_unit tscr_checker u_tscr_checker (.*);
